// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2cms check failed");

// clocked property that is also checked while reset is held
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("i2cms check failed");

`endif

// ===== hdl/i2cms_pkg.sv =====
// types, codes and helpers for the i2c master byte sequencer
package i2cms_pkg;

  // command codes, also the running command kind
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic [15:0] SLOT_TICKS_RST = 16'd175;
  localparam logic [4:0]  SHORT_STEPS    = 5'd4;
  localparam logic [4:0]  BYTE_STEPS     = 5'd28;
  localparam logic [4:0]  BIT_STEPS      = 5'd24;

  // one tick of input
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_item_t;

  // one tick of result
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       start_ok;
    logic       ack_seen;
    logic [7:0] rx_byte;
  } out_item_t;

  // split a step below 24 into bit number and phase: bit = s / 3, phase = s % 3
  function automatic logic [4:0] split_step(input logic [4:0] s);
    logic [8:0] p;
    logic [2:0] bit_no;
    logic [4:0] ph;
    p      = {4'd0, s} * 9'd11;
    bit_no = p[7:5];
    ph     = s - ({2'd0, bit_no} + {1'b0, bit_no, 1'b0});
    return {bit_no, ph[1:0]};
  endfunction

endpackage

// ===== hdl/i2c_master_byte_sequencer.sv =====
// top level: tick-driven i2c master running start, stop, write and read commands
// the result beat of an accepted input beat is registered and appears in the next cycle
// throughput: one beat per cycle while out_ready is high; the output register decouples the two sides
// each tick's bus state is updated by one pass of step logic into the state registers
// reset (rst_n low, synchronous) idles the sequencer, releases scl and sda, sets
// slot_ticks to 175 and empties the output register
module i2c_master_byte_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import i2cms_pkg::*;

  logic [15:0] slot_ticks_r;
  logic [15:0] slot_count_r, slot_count_nxt;
  op_t         kind_r, kind_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic [7:0]  tx_hold_r, tx_hold_nxt;
  logic        ack_hold_r, ack_hold_nxt;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;
  logic        accept;

  // step logic scratch
  logic        do_apply;
  logic        fail;
  logic        done;
  logic [4:0]  step_inc;
  logic [4:0]  step_cnt;
  logic [4:0]  split;
  logic [4:0]  rd_t;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // one tick of the sequencer
  always_comb begin
    slot_count_nxt = slot_count_r;
    kind_nxt       = kind_r;
    step_nxt       = step_r;
    shift_nxt      = shift_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_nxt        = ack_r;
    start_ok_nxt   = start_ok_r;
    tx_hold_nxt    = tx_hold_r;
    ack_hold_nxt   = ack_hold_r;
    do_apply       = 1'b0;
    fail           = 1'b0;
    done           = 1'b0;
    step_inc       = step_r + 5'd1;
    step_cnt       = ((kind_r == OP_START) || (kind_r == OP_STOP)) ? SHORT_STEPS : BYTE_STEPS;
    split          = 5'd0;
    rd_t           = 5'd0;

    // command launch, slot countdown or step advance
    if (kind_r == OP_NONE) begin
      if ((in_data.op >= OP_START) && (in_data.op <= OP_READ)) begin
        kind_nxt     = op_t'(in_data.op);
        step_nxt     = 5'd0;
        tx_hold_nxt  = in_data.tx_byte;
        ack_hold_nxt = in_data.ack_to_send;
        if (in_data.op == OP_START) start_ok_nxt = 1'b0;
        if (in_data.op == OP_READ) shift_nxt = 8'd0;
        do_apply = 1'b1;
      end
    end else if (slot_count_r != 16'd0) begin
      slot_count_nxt = slot_count_r - 16'd1;
    end else begin
      if (kind_r == OP_START) begin
        if ((step_r == 5'd1) && !in_data.sda_in) fail = 1'b1;
        if ((step_r == 5'd2) && in_data.sda_in) fail = 1'b1;
      end
      if (fail || (step_inc >= step_cnt)) begin
        if (!fail && (kind_r == OP_START)) start_ok_nxt = 1'b1;
        kind_nxt       = OP_NONE;
        step_nxt       = 5'd0;
        slot_count_nxt = 16'd0;
        done           = 1'b1;
      end else begin
        step_nxt = step_inc;
        do_apply = 1'b1;
      end
    end

    // pin action of the step just entered
    if (do_apply) begin
      unique case (kind_nxt)
        OP_START: begin
          unique case (step_nxt)
            5'd0:    sda_nxt = 1'b1;
            5'd1:    scl_nxt = 1'b1;
            5'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        OP_STOP: begin
          unique case (step_nxt)
            5'd0:    scl_nxt = 1'b0;
            5'd1:    sda_nxt = 1'b0;
            5'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        OP_WRITE: begin
          if (step_nxt < BIT_STEPS) begin
            split = split_step(step_nxt);
            unique case (split[1:0])
              2'd0:    sda_nxt = tx_hold_nxt[3'd7 - split[4:2]];
              2'd1:    scl_nxt = 1'b1;
              default: scl_nxt = 1'b0;
            endcase
          end else if (step_nxt == 5'd24) begin
            sda_nxt = 1'b1;
          end else if (step_nxt == 5'd25) begin
            scl_nxt = 1'b1;
          end else if (step_nxt == 5'd26) begin
            ack_nxt = in_data.sda_in;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        OP_READ: begin
          if (step_nxt == 5'd0) begin
            sda_nxt = 1'b1;
          end else if (step_nxt <= BIT_STEPS) begin
            rd_t  = step_nxt - 5'd1;
            split = split_step(rd_t);
            unique case (split[1:0])
              2'd0:    scl_nxt = 1'b1;
              2'd1:    shift_nxt = {shift_nxt[6:0], in_data.sda_in};
              default: scl_nxt = 1'b0;
            endcase
          end else if (step_nxt == 5'd25) begin
            sda_nxt = ack_hold_nxt;
          end else if (step_nxt == 5'd26) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: ;
      endcase
      // hold time for the new action, zero counts as one
      slot_count_nxt = (slot_ticks_r == 16'd0) ? 16'd0 : (slot_ticks_r - 16'd1);
    end

    // result beat
    out_nxt.scl_level = scl_nxt;
    out_nxt.sda_level = sda_nxt;
    out_nxt.busy_res  = (kind_nxt != OP_NONE);
    out_nxt.done_res  = done;
    out_nxt.start_ok  = start_ok_nxt;
    out_nxt.ack_seen  = ack_nxt;
    out_nxt.rx_byte   = shift_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_ticks_r <= SLOT_TICKS_RST;
    end else if (cfg_we) begin
      slot_ticks_r <= cfg_wdata;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= 16'd0;
      kind_r       <= OP_NONE;
      step_r       <= 5'd0;
      shift_r      <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_r        <= 1'b1;
      start_ok_r   <= 1'b0;
      tx_hold_r    <= 8'd0;
      ack_hold_r   <= 1'b1;
    end else if (accept) begin
      slot_count_r <= slot_count_nxt;
      kind_r       <= kind_nxt;
      step_r       <= step_nxt;
      shift_r      <= shift_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_r        <= ack_nxt;
      start_ok_r   <= start_ok_nxt;
      tx_hold_r    <= tx_hold_nxt;
      ack_hold_r   <= ack_hold_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/i2cms_checker.sv =====
// port-level checker for the i2c master byte sequencer, with its bind
`include "assert_macros.svh"

module i2cms_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cms_pkg::out_item_t out_data
);
  import i2cms_pkg::*;

  // a stalled result beat stays
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  // a stalled result beat keeps its payload
  `ASSERT_CLK(a_out_stable, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_data))
  // an empty output register always takes a beat
  `ASSERT_CLK(a_ready_empty, clk, rst_n, !out_valid |-> in_ready)
  // a finishing tick never reports busy
  `ASSERT_CLK(a_done_idle, clk, rst_n, (out_valid && out_data.done_res) |-> !out_data.busy_res)
  // every accepted beat shows up as a result in the next cycle
  `ASSERT_CLK(a_beat_out, clk, rst_n, (in_valid && in_ready) |=> out_valid)

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_i2cms_checker (.*);
